[design/sp2w_pkg.sv]
// Package for the sonar polar-to-world point block.
// Holds the CORDIC word types, the arctangent table and register indexes.
// No dependencies.
package sp2w_pkg;

  localparam int NUM_STEPS = 16;
  localparam int NUM_LANES = 5;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 31;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [31:0] ATAN_TBL [0:NUM_STEPS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  // lane order
  localparam int LN_ROLL  = 0;
  localparam int LN_PITCH = 1;
  localparam int LN_YAW   = 2;
  localparam int LN_BEAR  = 3;
  localparam int LN_ELEV  = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROLL  = 3'd0,
    REG_PITCH = 3'd1,
    REG_YAW   = 3'd2,
    REG_ORG_X = 3'd3,
    REG_ORG_Y = 3'd4,
    REG_ORG_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic  [NUM_LANES-1:0] flip;
    logic  [15:0]          rng;
  } cw_t;

endpackage

[design/sp2w_in_if.sv]
// Input channel: one sonar return word per handshake.
// No dependencies.
interface sp2w_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        range_dist;
  logic signed [15:0] bearing_angle;
  logic signed [15:0] elevation_angle;

  modport source (output valid, range_dist, bearing_angle, elevation_angle, input ready);
  modport sink   (input valid, range_dist, bearing_angle, elevation_angle, output ready);
endinterface

[design/sp2w_out_if.sv]
// Result channel: one world point word per handshake.
// No dependencies.
interface sp2w_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

[design/sp2w_cordic_cell.sv]
// One CORDIC rotation step over all five angle lanes, with its own
// valid bit and stall logic. Depends on sp2w_pkg.
module sp2w_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           v_in,
  output logic           rdy_out,
  input  sp2w_pkg::cw_t  d_in,
  output logic           v_out,
  input  logic           rdy_in,
  output sp2w_pkg::cw_t  d_out
);
  import sp2w_pkg::*;

  logic v_r;
  cw_t  d_r, d_nxt;
  logic en;

  assign en      = !v_r || rdy_in;
  assign rdy_out = en;
  assign v_out   = v_r;
  assign d_out   = d_r;

  always_comb begin
    logic signed [31:0] x, y, z;
    d_nxt = d_in;
    for (int l = 0; l < NUM_LANES; l++) begin
      x = d_in.lane[l].x;
      y = d_in.lane[l].y;
      z = d_in.lane[l].z;
      if (!z[31]) begin
        d_nxt.lane[l].x = x - (y >>> STEP);
        d_nxt.lane[l].y = y + (x >>> STEP);
        d_nxt.lane[l].z = z - ATAN_TBL[STEP];
      end else begin
        d_nxt.lane[l].x = x + (y >>> STEP);
        d_nxt.lane[l].y = y - (x >>> STEP);
        d_nxt.lane[l].z = z + ATAN_TBL[STEP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

[design/sp2w_rot_math.sv]
// Back end: sine/cosine rounding, rotation matrix, sonar point,
// matrix-vector product and origin add, five stages. Depends on sp2w_pkg.
module sp2w_rot_math (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_in,
  output logic               rdy_out,
  input  sp2w_pkg::cw_t      d_in,
  input  logic signed [30:0] org_x,
  input  logic signed [30:0] org_y,
  input  logic signed [30:0] org_z,
  output logic               v_out,
  input  logic               rdy_in,
  output logic signed [31:0] wx,
  output logic signed [31:0] wy,
  output logic signed [31:0] wz
);
  import sp2w_pkg::*;

  function automatic logic signed [15:0] q15(input logic signed [31:0] v, input logic flip);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [15:0] c;
    t = {v[31], v} + 33'sd16384;
    r = t[32:15];
    if (r > 18'sd32767)       c = 16'sd32767;
    else if (r < -18'sd32767) c = -16'sd32767;
    else                      c = r[15:0];
    return flip ? -c : c;
  endfunction

  function automatic logic signed [33:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    return {t[47], t[47:15]};
  endfunction

  // stage valid bits and enables
  logic v_f_r, v_1_r, v_2_r, v_3_r, v_4_r;
  logic en_f, en_1, en_2, en_3, en_4;

  assign en_4    = !v_4_r || rdy_in;
  assign en_3    = !v_3_r || en_4;
  assign en_2    = !v_2_r || en_3;
  assign en_1    = !v_1_r || en_2;
  assign en_f    = !v_f_r || en_1;
  assign rdy_out = en_f;
  assign v_out   = v_4_r;

  // stage F
  logic signed [15:0] sn_r [NUM_LANES];
  logic signed [15:0] cs_r [NUM_LANES];
  logic [15:0]        rng_r;

  // stage 1
  logic signed [31:0] cysp_r, sysp_r, cycp_r, sycp_r, cpsr_r, cpcr_r;
  logic signed [31:0] sycr_r, sysr_r, cycr_r, cysr_r, nsp_r;
  logic signed [32:0] h_r, zr_r;
  logic signed [15:0] cb_r, sb_r, sr1_r, cr1_r;

  // stage 2
  logic signed [33:0] m_r [9];
  logic signed [25:0] p_r [3];

  // stage 3
  logic signed [59:0] pr_r [9];

  logic signed [31:0] wx_r, wy_r, wz_r;
  assign wx = wx_r;
  assign wy = wy_r;
  assign wz = wz_r;

  // stage 1 products
  logic signed [31:0] cysp_nxt, sysp_nxt, cycp_nxt, sycp_nxt, cpsr_nxt, cpcr_nxt;
  logic signed [31:0] sycr_nxt, sysr_nxt, cycr_nxt, cysr_nxt, nsp_nxt;
  logic signed [32:0] h_nxt, zr_nxt;
  always_comb begin
    logic signed [16:0] rs;
    logic signed [16:0] nsp;
    rs       = $signed({1'b0, rng_r});
    cysp_nxt = cs_r[LN_YAW] * sn_r[LN_PITCH];
    sysp_nxt = sn_r[LN_YAW] * sn_r[LN_PITCH];
    cycp_nxt = cs_r[LN_YAW] * cs_r[LN_PITCH];
    sycp_nxt = sn_r[LN_YAW] * cs_r[LN_PITCH];
    cpsr_nxt = cs_r[LN_PITCH] * sn_r[LN_ROLL];
    cpcr_nxt = cs_r[LN_PITCH] * cs_r[LN_ROLL];
    sycr_nxt = sn_r[LN_YAW] * cs_r[LN_ROLL];
    sysr_nxt = sn_r[LN_YAW] * sn_r[LN_ROLL];
    cycr_nxt = cs_r[LN_YAW] * cs_r[LN_ROLL];
    cysr_nxt = cs_r[LN_YAW] * sn_r[LN_ROLL];
    nsp      = -{sn_r[LN_PITCH][15], sn_r[LN_PITCH]};
    nsp_nxt  = {nsp[16:0], 15'd0};
    h_nxt    = rs * cs_r[LN_ELEV];
    zr_nxt   = rs * sn_r[LN_ELEV];
  end

  // stage 2 matrix and point
  logic signed [33:0] m_nxt [9];
  logic signed [25:0] p_nxt [3];
  always_comb begin
    logic signed [47:0] a, b, c, d;
    logic signed [48:0] hx, hy;
    logic signed [32:0] zt;
    a = cysp_r * sr1_r;
    b = cysp_r * cr1_r;
    c = sysp_r * sr1_r;
    d = sysp_r * cr1_r;
    m_nxt[0] = {{2{cycp_r[31]}}, cycp_r};
    m_nxt[1] = rnd15(a) - {{2{sycr_r[31]}}, sycr_r};
    m_nxt[2] = rnd15(b) + {{2{sysr_r[31]}}, sysr_r};
    m_nxt[3] = {{2{sycp_r[31]}}, sycp_r};
    m_nxt[4] = rnd15(c) + {{2{cycr_r[31]}}, cycr_r};
    m_nxt[5] = rnd15(d) - {{2{cysr_r[31]}}, cysr_r};
    m_nxt[6] = {{2{nsp_r[31]}}, nsp_r};
    m_nxt[7] = {{2{cpsr_r[31]}}, cpsr_r};
    m_nxt[8] = {{2{cpcr_r[31]}}, cpcr_r};
    hx = h_r * cb_r + 49'sd2097152;
    hy = h_r * sb_r + 49'sd2097152;
    zt = zr_r + 33'sd64;
    p_nxt[0] = hx[47:22];
    p_nxt[1] = hy[47:22];
    p_nxt[2] = zt[32:7];
  end

  // stage 4 sums
  logic signed [31:0] w_nxt [3];
  always_comb begin
    logic signed [61:0] acc;
    logic signed [31:0] o;
    for (int i = 0; i < 3; i++) begin
      acc = 62'(pr_r[3*i]) + 62'(pr_r[3*i+1]) + 62'(pr_r[3*i+2])
            + (62'sd1 <<< 37);
      case (i)
        0:       o = {org_x[30], org_x};
        1:       o = {org_y[30], org_y};
        default: o = {org_z[30], org_z};
      endcase
      w_nxt[i] = {{8{acc[61]}}, acc[61:38]} + o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
      v_1_r <= 1'b0;
      v_2_r <= 1'b0;
      v_3_r <= 1'b0;
      v_4_r <= 1'b0;
    end else begin
      if (en_f) v_f_r <= v_in;
      if (en_1) v_1_r <= v_f_r;
      if (en_2) v_2_r <= v_1_r;
      if (en_3) v_3_r <= v_2_r;
      if (en_4) v_4_r <= v_3_r;
    end
    if (en_f) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        sn_r[l] <= q15(d_in.lane[l].y, d_in.flip[l]);
        cs_r[l] <= q15(d_in.lane[l].x, d_in.flip[l]);
      end
      rng_r <= d_in.rng;
    end
    if (en_1) begin
      cysp_r <= cysp_nxt;
      sysp_r <= sysp_nxt;
      cycp_r <= cycp_nxt;
      sycp_r <= sycp_nxt;
      cpsr_r <= cpsr_nxt;
      cpcr_r <= cpcr_nxt;
      sycr_r <= sycr_nxt;
      sysr_r <= sysr_nxt;
      cycr_r <= cycr_nxt;
      cysr_r <= cysr_nxt;
      nsp_r  <= nsp_nxt;
      h_r    <= h_nxt;
      zr_r   <= zr_nxt;
      cb_r   <= cs_r[LN_BEAR];
      sb_r   <= sn_r[LN_BEAR];
      sr1_r  <= sn_r[LN_ROLL];
      cr1_r  <= cs_r[LN_ROLL];
    end
    if (en_2) begin
      m_r <= m_nxt;
      p_r <= p_nxt;
    end
    if (en_3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[3*i+j] <= m_r[3*i+j] * p_r[j];
        end
      end
    end
    if (en_4) begin
      wx_r <= w_nxt[0];
      wy_r <= w_nxt[1];
      wz_r <= w_nxt[2];
    end
  end

endmodule

[design/sonar_polar_to_world_point_top.sv]
// Top level of the sonar polar-to-world point block.
// Uses sp2w_pkg, sp2w_in_if, sp2w_out_if, sp2w_cordic_cell, sp2w_rot_math.
//
// Usage:
//   in_w carries one sonar return word (range, bearing, elevation); out_w
//   carries one world point word per input word, in order. cfg_we/cfg_idx/
//   cfg_data write roll, pitch, yaw (binary angles) and the sensor origin;
//   write only while no word is in flight.
//   Path from input handshake to out_w.valid: 16 CORDIC cells, one
//   rounding stage, three multiply stages and one sum stage.
//   Throughput: one word per cycle while out_w.ready is high; every stage
//   is a register with its own valid bit, so bubbles close up when the
//   receiver stalls and input is still taken until the whole chain is full.
//   Reset (rst_n low, synchronous) empties the chain and clears all
//   configuration registers to zero.
module sonar_polar_to_world_point_top (
  input  logic                          clk,
  input  logic                          rst_n,
  sp2w_in_if.sink                       in_w,
  sp2w_out_if.source                    out_w,
  input  logic                          cfg_we,
  input  logic [sp2w_pkg::CFG_AW-1:0]   cfg_idx,
  input  logic [sp2w_pkg::CFG_DW-1:0]   cfg_data
);
  import sp2w_pkg::*;

  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic signed [30:0] org_x_r, org_y_r, org_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROLL:  roll_r  <= cfg_data[15:0];
        REG_PITCH: pitch_r <= cfg_data[15:0];
        REG_YAW:   yaw_r   <= cfg_data[15:0];
        REG_ORG_X: org_x_r <= cfg_data;
        REG_ORG_Y: org_y_r <= cfg_data;
        REG_ORG_Z: org_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // fold angles into [-pi/2, pi/2] and seed the lanes
  cw_t seed;
  always_comb begin
    logic signed [15:0] ang [NUM_LANES];
    logic signed [16:0] a;
    ang[LN_ROLL]  = roll_r;
    ang[LN_PITCH] = pitch_r;
    ang[LN_YAW]   = yaw_r;
    ang[LN_BEAR]  = in_w.bearing_angle;
    ang[LN_ELEV]  = in_w.elevation_angle;
    seed.rng = in_w.range_dist;
    for (int l = 0; l < NUM_LANES; l++) begin
      a = {ang[l][15], ang[l]};
      seed.flip[l] = 1'b0;
      if (a > 17'sd16384) begin
        a = a - 17'sd32768;
        seed.flip[l] = 1'b1;
      end else if (a < -17'sd16384) begin
        a = a + 17'sd32768;
        seed.flip[l] = 1'b1;
      end
      seed.lane[l].x = CORDIC_GAIN;
      seed.lane[l].y = '0;
      seed.lane[l].z = {a[15:0], 16'd0};
    end
  end

  logic v_c   [NUM_STEPS+1];
  logic rdy_c [NUM_STEPS+1];
  cw_t  d_c   [NUM_STEPS+1];

  assign v_c[0]     = in_w.valid;
  assign d_c[0]     = seed;
  assign in_w.ready = rdy_c[0];

  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_cell
    sp2w_cordic_cell #(.STEP(s)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (v_c[s]),
      .rdy_out (rdy_c[s]),
      .d_in    (d_c[s]),
      .v_out   (v_c[s+1]),
      .rdy_in  (rdy_c[s+1]),
      .d_out   (d_c[s+1])
    );
  end

  sp2w_rot_math u_math (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_in    (v_c[NUM_STEPS]),
    .rdy_out (rdy_c[NUM_STEPS]),
    .d_in    (d_c[NUM_STEPS]),
    .org_x   (org_x_r),
    .org_y   (org_y_r),
    .org_z   (org_z_r),
    .v_out   (out_w.valid),
    .rdy_in  (out_w.ready),
    .wx      (out_w.world_x),
    .wy      (out_w.world_y),
    .wz      (out_w.world_z)
  );

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_w.valid)
    else $error("result valid right after reset");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_w.ready |-> in_w.ready)
    else $error("input stalled while output drains");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_w.ready |-> v_c[1])
    else $error("input stalled with first cell empty");

endmodule
